[rtl/core/assert_macros.svh]
// assertion macros for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// expression holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/core/ssmp_pkg.sv]
package ssmp_pkg;

   // field widths
   localparam int DUTY_W   = 8;
   localparam int REV_W    = 16;
   localparam int RAMP_W   = 16;
   localparam int KIND_W   = 2;
   localparam int POS_W    = 2;
   localparam int STAT_W   = 2;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int CSR_IW   = 3;
   localparam int REQ_DW   = 8;
   localparam int RSP_DW   = 32;
   localparam int RSP_USED = DUTY_W + 3 + STAT_W + REV_W;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PULSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd3;

   // move positions
   localparam logic [POS_W-1:0] POS_FULL = 2'd0;
   localparam logic [POS_W-1:0] POS_HALF = 2'd1;
   localparam logic [POS_W-1:0] POS_DOWN = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_IDLE = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DOWN = 2'd3;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_START_DUTY = 3'd0;
   localparam logic [CSR_IW-1:0] REG_FULL_DUTY  = 3'd1;
   localparam logic [CSR_IW-1:0] REG_RAMP_TIME  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_FULL_REVS  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_HALF_REVS  = 3'd4;
   localparam logic [CSR_IW-1:0] REG_DOWN_REVS  = 3'd5;

   // register reset values
   localparam logic [DUTY_W-1:0] RST_START_DUTY = 8'd50;
   localparam logic [DUTY_W-1:0] RST_FULL_DUTY  = 8'd255;
   localparam logic [RAMP_W-1:0] RST_RAMP_TIME  = 16'd1000;
   localparam logic [REV_W-1:0]  RST_FULL_REVS  = 16'd10;
   localparam logic [REV_W-1:0]  RST_HALF_REVS  = 16'd5;
   localparam logic [REV_W-1:0]  RST_DOWN_REVS  = 16'd0;

   typedef struct packed {
      logic [DUTY_W-1:0] start_duty;
      logic [DUTY_W-1:0] full_duty;
      logic [RAMP_W-1:0] ramp_time_ms;
      logic [REV_W-1:0]  full_revs;
      logic [REV_W-1:0]  half_revs;
      logic [REV_W-1:0]  down_revs;
   } ssmp_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic run_item;
      logic div_start;
      logic apply_step;
      logic load_rsp;
   } ssmp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_step;
      logic div_done;
      logic rsp_free;
   } ssmp_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } ssmp_state_type;

endpackage

[rtl/core/soft_start_motor_positioner_unit.sv]
// soft start motor positioner
// req channel: one beat per event; tuser carries the kind (tick, sensor pulse,
// move, emergency stop), tdata carries the move position. rsp channel: one beat
// per req beat with the duty, bridge inputs, moving flag, status and the
// revolution count as they stand after that event.
// csr port: six registers at byte addresses 0 to 20, which the user must write
// only while no beat is in flight; the block does not enforce this. pready is
// always high and reads return the stored value. each beat is accepted in the
// idle state, run in the exec state and loaded into the result register in the
// out state; a tick that takes a ramp step also runs the step divider in the div
// state, one quotient bit a cycle over 8 + clog2(STEP_INTERVAL_MS + 1) bits.
// one beat is worked on at a time; the next one is accepted while the last
// result still waits in the output register, and a stalled rsp side holds
// further results back until that register frees.
// reset: motor stopped, count and target zero, step timer saturated, and the
// registers back at their defaults (start 50, full 255, ramp 1000 ms,
// targets 10, 5 and 0 revolutions).
module soft_start_motor_positioner_unit #(
   parameter int STEP_INTERVAL_MS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: position[1:0], zeros[7:2]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ssmp_pkg::REQ_DW-1:0] req_tdata,
   // req_tuser: kind[1:0]
   input  logic [ssmp_pkg::KIND_W-1:0] req_tuser,
   // rsp_tdata: duty[7:0], drive_forward[8], drive_reverse[9], is_moving[10],
   // status[12:11], rev_count[28:13], zeros[31:29]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ssmp_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ssmp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ssmp_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ssmp_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import ssmp_pkg::*;

   ssmp_cfg_type  cfg;
   ssmp_cmd_type  cmd;
   ssmp_stat_type stat;

   ssmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssmp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ssmp_datapath #(
      .STEP_INTERVAL_MS (STEP_INTERVAL_MS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg),
      .req_kind   (req_tuser),
      .req_pos    (req_tdata[POS_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/ssmp_csr.sv]
module ssmp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ssmp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ssmp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ssmp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output ssmp_pkg::ssmp_cfg_type        cfg
);
   import ssmp_pkg::*;

   ssmp_cfg_type      cfg_ff, cfg_in;
   logic [CSR_IW-1:0] index;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_START_DUTY: cfg_in.start_duty   = csr_pwdata[DUTY_W-1:0];
            REG_FULL_DUTY:  cfg_in.full_duty    = csr_pwdata[DUTY_W-1:0];
            REG_RAMP_TIME:  cfg_in.ramp_time_ms = csr_pwdata[RAMP_W-1:0];
            REG_FULL_REVS:  cfg_in.full_revs    = csr_pwdata[REV_W-1:0];
            REG_HALF_REVS:  cfg_in.half_revs    = csr_pwdata[REV_W-1:0];
            REG_DOWN_REVS:  cfg_in.down_revs    = csr_pwdata[REV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_duty   <= RST_START_DUTY;
         cfg_ff.full_duty    <= RST_FULL_DUTY;
         cfg_ff.ramp_time_ms <= RST_RAMP_TIME;
         cfg_ff.full_revs    <= RST_FULL_REVS;
         cfg_ff.half_revs    <= RST_HALF_REVS;
         cfg_ff.down_revs    <= RST_DOWN_REVS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (index)
         REG_START_DUTY: csr_prdata = CSR_DW'(cfg_ff.start_duty);
         REG_FULL_DUTY:  csr_prdata = CSR_DW'(cfg_ff.full_duty);
         REG_RAMP_TIME:  csr_prdata = CSR_DW'(cfg_ff.ramp_time_ms);
         REG_FULL_REVS:  csr_prdata = CSR_DW'(cfg_ff.full_revs);
         REG_HALF_REVS:  csr_prdata = CSR_DW'(cfg_ff.half_revs);
         REG_DOWN_REVS:  csr_prdata = CSR_DW'(cfg_ff.down_revs);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

[rtl/core/ssmp_div.sv]
module ssmp_div #(
   parameter int DW = 12,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   import ssmp_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] work_ff, work_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, work_ff[DW-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      work_in = work_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         work_in = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[VW-1:0] : trial[VW-1:0];
         work_in = {work_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

[rtl/core/ssmp_datapath.sv]
`include "assert_macros.svh"

module ssmp_datapath #(
   parameter int STEP_INTERVAL_MS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssmp_pkg::ssmp_cmd_type        cmd,
   output ssmp_pkg::ssmp_stat_type       stat,
   input  ssmp_pkg::ssmp_cfg_type        cfg,
   input  logic [ssmp_pkg::KIND_W-1:0]   req_kind,
   input  logic [ssmp_pkg::POS_W-1:0]    req_pos,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [ssmp_pkg::RSP_DW-1:0]   rsp_tdata
);
   import ssmp_pkg::*;

   localparam int MSW = $clog2(STEP_INTERVAL_MS + 1);
   localparam int DW  = DUTY_W + MSW;
   localparam int SW  = DW + 1;
   localparam logic [MSW-1:0] STEP_MS = MSW'(STEP_INTERVAL_MS);

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              moving_ff, moving_in;
   logic              ramping_ff, ramping_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [REV_W-1:0]  count_ff, count_in;
   logic [REV_W-1:0]  target_ff, target_in;
   logic [MSW-1:0]    ms_ff, ms_in;
   logic              fwd_ff, fwd_in;
   logic              rev_ff, rev_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   logic [MSW-1:0]    ms_inc;
   logic              need_step;
   logic              reached;
   logic              halt;
   logic [DUTY_W-1:0] span;
   logic [DW-1:0]     dividend;
   logic [RAMP_W-1:0] divisor;
   logic              div_done;
   logic [DW-1:0]     quotient;
   logic [DW-1:0]     step;
   logic [SW-1:0]     sum;

   // ramp step size: span * interval / ramp time
   assign span     = (cfg.full_duty > cfg.start_duty) ? (cfg.full_duty - cfg.start_duty) : '0;
   assign dividend = DW'(span) * DW'(STEP_MS);
   assign divisor  = (cfg.ramp_time_ms == '0) ? RAMP_W'(1) : cfg.ramp_time_ms;

   ssmp_div #(
      .DW (DW),
      .VW (RAMP_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign step = (quotient == '0) ? DW'(1) : quotient;
   assign sum  = SW'(duty_ff) + SW'(step);

   // status back to the controller
   assign ms_inc         = (ms_ff < STEP_MS) ? ms_ff + MSW'(1) : ms_ff;
   assign need_step      = (kind_ff == KIND_TICK) && moving_ff && ramping_ff &&
                           (ms_inc >= STEP_MS);
   assign reached        = count_ff >= target_ff;
   assign stat.need_step = need_step;
   assign stat.div_done  = div_done;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   // motor state update
   always_comb begin
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      moving_in    = moving_ff;
      ramping_in   = ramping_ff;
      duty_in      = duty_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      ms_in        = ms_ff;
      fwd_in       = fwd_ff;
      rev_in       = rev_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      halt         = 1'b0;

      if (cmd.take_item) begin
         kind_in = req_kind;
         pos_in  = req_pos;
      end

      if (cmd.run_item) begin
         case (kind_ff)
            KIND_TICK: begin
               if (need_step) begin
                  ms_in = '0;
               end else begin
                  ms_in = ms_inc;
                  halt  = moving_ff && reached;
               end
            end
            KIND_PULSE: begin
               if (count_ff != '1) begin
                  count_in = count_ff + REV_W'(1);
               end
            end
            KIND_MOVE: begin
               // position code three is ignored
               if (pos_ff == POS_FULL || pos_ff == POS_HALF || pos_ff == POS_DOWN) begin
                  count_in   = '0;
                  moving_in  = 1'b1;
                  ramping_in = 1'b1;
                  duty_in    = cfg.start_duty;
                  fwd_in     = pos_ff != POS_DOWN;
                  rev_in     = pos_ff == POS_DOWN;
                  status_in  = STAT_W'(pos_ff) + STAT_W'(1);
                  case (pos_ff)
                     POS_FULL: target_in = cfg.full_revs;
                     POS_HALF: target_in = cfg.half_revs;
                     default:  target_in = cfg.down_revs;
                  endcase
               end
            end
            default: begin
               halt = 1'b1;
            end
         endcase
      end

      // ramp step, then the target check of the same tick
      if (cmd.apply_step) begin
         if (sum >= SW'(cfg.full_duty)) begin
            duty_in    = cfg.full_duty;
            ramping_in = 1'b0;
         end else begin
            duty_in = sum[DUTY_W-1:0];
         end
         halt = reached;
      end

      if (halt) begin
         duty_in   = '0;
         fwd_in    = 1'b0;
         rev_in    = 1'b0;
         moving_in = 1'b0;
         status_in = STAT_IDLE;
      end

      // result register
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DW - RSP_USED){1'b0}}, count_ff, status_ff, moving_ff,
                         rev_ff, fwd_ff, duty_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff    <= 1'b0;
         ramping_ff   <= 1'b0;
         duty_ff      <= '0;
         count_ff     <= '0;
         target_ff    <= '0;
         ms_ff        <= STEP_MS;
         fwd_ff       <= 1'b0;
         rev_ff       <= 1'b0;
         status_ff    <= STAT_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         moving_ff    <= moving_in;
         ramping_ff   <= ramping_in;
         duty_ff      <= duty_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         ms_ff        <= ms_in;
         fwd_ff       <= fwd_in;
         rev_ff       <= rev_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // consistency of the drive state
   `ASSERT_ALWAYS(a_moving_status, clock, reset, moving_ff == (status_ff != STAT_IDLE))
   `ASSERT_ALWAYS(a_bridge_dir, clock, reset, rev_ff == (status_ff == STAT_DOWN))
   `ASSERT_IMPLY(a_stopped_duty, clock, reset, !moving_ff, duty_ff == '0 && !fwd_ff && !rev_ff)

endmodule

[rtl/core/ssmp_ctrl.sv]
module ssmp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  ssmp_pkg::ssmp_stat_type  stat,
   output ssmp_pkg::ssmp_cmd_type   cmd
);
   import ssmp_pkg::*;

   ssmp_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            state_in = ST_EXEC;
         end
         ST_EXEC: state_in = stat.need_step ? ST_DIV : ST_OUT;
         ST_DIV:  if (stat.div_done) begin
            state_in = ST_OUT;
         end
         ST_OUT:  if (stat.rsp_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_item = req_tvalid;
         end
         ST_EXEC: begin
            cmd.run_item  = 1'b1;
            cmd.div_start = stat.need_step;
         end
         ST_DIV:  cmd.apply_step = stat.div_done;
         ST_OUT:  cmd.load_rsp   = stat.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[bench/tb_soft_start_motor_positioner_unit.sv]
module tb_soft_start_motor_positioner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ssmp_pkg::*;

   localparam int STEP_MS = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES = 8;
   localparam logic [POS_W-1:0] POS_NONE = 2'd3;
   localparam logic [REV_W-1:0] REV_MAX = 16'hFFFF;

   // outputs of one beat, laid out as in rsp_tdata
   typedef struct packed {
      logic [REV_W-1:0]  rev_count;
      logic [STAT_W-1:0] status;
      logic              moving;
      logic              reverse;
      logic              forward;
      logic [DUTY_W-1:0] duty;
   } motor_view_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]   req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   soft_start_motor_positioner_unit dut (.*);

   // shadow of the registers and the motor state
   ssmp_cfg_type        cfg_shadow;
   logic                motor_on;
   logic                ramp_on;
   logic [DUTY_W-1:0]   duty_q;
   logic [REV_W-1:0]    count_q;
   logic [REV_W-1:0]    target_q;
   int unsigned         ms_elapsed;
   logic                fwd_q;
   logic                rev_q;
   logic [STAT_W-1:0]   status_q;

   motor_view_type      due_motor_states[$];
   int unsigned         mismatch_count = 0;
   int unsigned         items_sent = 0;
   bit                  no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic void reset_motor_shadow();
      cfg_shadow.start_duty   = RST_START_DUTY;
      cfg_shadow.full_duty    = RST_FULL_DUTY;
      cfg_shadow.ramp_time_ms = RST_RAMP_TIME;
      cfg_shadow.full_revs    = RST_FULL_REVS;
      cfg_shadow.half_revs    = RST_HALF_REVS;
      cfg_shadow.down_revs    = RST_DOWN_REVS;
      motor_on   = 1'b0;
      ramp_on    = 1'b0;
      duty_q     = '0;
      count_q    = '0;
      target_q   = '0;
      ms_elapsed = STEP_MS;
      fwd_q      = 1'b0;
      rev_q      = 1'b0;
      status_q   = STAT_IDLE;
   endfunction

   function automatic void stop_motor();
      fwd_q    = 1'b0;
      rev_q    = 1'b0;
      duty_q   = '0;
      motor_on = 1'b0;
      status_q = STAT_IDLE;
   endfunction

   // apply one event to the shadow and queue the outputs it leaves
   function automatic void advance_motor(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos);
      int unsigned span, stepv, total, ramp;
      motor_view_type view;
      case (kind)
         KIND_TICK: begin
            if (ms_elapsed < STEP_MS) ms_elapsed++;
            if (motor_on) begin
               if (ramp_on && ms_elapsed >= STEP_MS) begin
                  ms_elapsed = 0;
                  ramp = (cfg_shadow.ramp_time_ms == 0) ? 1 : cfg_shadow.ramp_time_ms;
                  stepv = 1;
                  if (cfg_shadow.full_duty > cfg_shadow.start_duty) begin
                     span = cfg_shadow.full_duty - cfg_shadow.start_duty;
                     stepv = span * STEP_MS / ramp;
                     if (stepv < 1) stepv = 1;
                  end
                  total = duty_q + stepv;
                  if (total >= cfg_shadow.full_duty) begin
                     total = cfg_shadow.full_duty;
                     ramp_on = 1'b0;
                  end
                  duty_q = total[DUTY_W-1:0];
               end
               if (count_q >= target_q) stop_motor();
            end
         end
         KIND_PULSE: begin
            if (count_q != REV_MAX) count_q++;
         end
         KIND_MOVE: begin
            if (pos != POS_NONE) begin
               count_q  = '0;
               motor_on = 1'b1;
               ramp_on  = 1'b1;
               duty_q   = cfg_shadow.start_duty;
               case (pos)
                  POS_FULL: target_q = cfg_shadow.full_revs;
                  POS_HALF: target_q = cfg_shadow.half_revs;
                  default:  target_q = cfg_shadow.down_revs;
               endcase
               fwd_q    = (pos != POS_DOWN);
               rev_q    = (pos == POS_DOWN);
               status_q = pos + 2'd1;
            end
         end
         default: stop_motor();
      endcase
      view.duty      = duty_q;
      view.forward   = fwd_q;
      view.reverse   = rev_q;
      view.moving    = motor_on;
      view.status    = status_q;
      view.rev_count = count_q;
      due_motor_states.push_back(view);
   endfunction

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
      return $urandom_range(0, 2);
   endfunction

   function automatic void check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d, got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   // result side: random stalls unless idling is switched off
   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (no_idle) begin
            rsp_tready <= 1'b1;
            hold = 0;
         end else if (hold != 0) begin
            hold--;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(0, 6);
         end else begin
            rsp_tready <= 1'b0;
            hold = gap_len();
         end
      end
   end

   // compare every result beat with the oldest queued state
   always @(posedge clock) begin
      motor_view_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = motor_view_type'(rsp_tdata[RSP_USED-1:0]);
         if (due_motor_states.size() == 0) begin
            $display("%0t unexpected result beat: expected none, got %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = due_motor_states.pop_front();
            check_field("duty", want.duty, got.duty);
            check_field("drive_forward", want.forward, got.forward);
            check_field("drive_reverse", want.reverse, got.reverse);
            check_field("is_moving", want.moving, got.moving);
            check_field("status", want.status, got.status);
            check_field("rev_count", want.rev_count, got.rev_count);
         end
      end
   end

   // one event beat, then a random gap unless idling is switched off
   task automatic send_event(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DW-POS_W){1'b0}}, pos};
      do @(posedge clock); while (!req_tready);
      advance_motor(kind, pos);
      if (!(kind == KIND_MOVE && pos == POS_NONE)) items_sent++;
      gap = no_idle ? 0 : gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_motor_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, then read back
   task automatic csr_write(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] mask, seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_START_DUTY: cfg_shadow.start_duty   = value[DUTY_W-1:0];
         REG_FULL_DUTY:  cfg_shadow.full_duty    = value[DUTY_W-1:0];
         REG_RAMP_TIME:  cfg_shadow.ramp_time_ms = value[RAMP_W-1:0];
         REG_FULL_REVS:  cfg_shadow.full_revs    = value[REV_W-1:0];
         REG_HALF_REVS:  cfg_shadow.half_revs    = value[REV_W-1:0];
         default:        cfg_shadow.down_revs    = value[REV_W-1:0];
      endcase
      mask = (idx == REG_START_DUTY || idx == REG_FULL_DUTY) ? 32'h0000_00FF : 32'h0000_FFFF;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      if (seen !== (value & mask)) begin
         $display("%0t mismatch csr %0d readback: expected %h, got %h",
                  $time, idx, value & mask, seen);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [DUTY_W-1:0] start_d, input logic [DUTY_W-1:0] full_d,
                                input logic [RAMP_W-1:0] ramp_ms, input logic [REV_W-1:0] full_r,
                                input logic [REV_W-1:0] half_r, input logic [REV_W-1:0] down_r);
      settle();
      csr_write(REG_START_DUTY, start_d);
      csr_write(REG_FULL_DUTY, full_d);
      csr_write(REG_RAMP_TIME, ramp_ms);
      csr_write(REG_FULL_REVS, full_r);
      csr_write(REG_HALF_REVS, half_r);
      csr_write(REG_DOWN_REVS, down_r);
   endtask

   // ticks, pulses and e-stop with the motor stopped
   task automatic test_idle_events();
      send_event(KIND_TICK, POS_FULL);
      send_event(KIND_PULSE, POS_NONE);
      send_event(KIND_PULSE, POS_DOWN);
      send_event(KIND_STOP, POS_HALF);
      send_event(KIND_TICK, POS_NONE);
   endtask

   // every position at reset settings, ignored position, restart, e-stop
   task automatic test_move_commands();
      send_event(KIND_MOVE, POS_FULL);
      send_event(KIND_TICK, POS_FULL);
      repeat (3) send_event(KIND_PULSE, POS_FULL);
      send_event(KIND_MOVE, POS_HALF);
      send_event(KIND_MOVE, POS_NONE);
      send_event(KIND_MOVE, POS_DOWN);
      send_event(KIND_TICK, POS_FULL);
      send_event(KIND_STOP, POS_FULL);
      send_event(KIND_MOVE, POS_HALF);
      send_event(KIND_STOP, POS_FULL);
   endtask

   // widest ramp, no ramp span, ramp time zero
   task automatic test_ramp_corners();
      apply_setting(8'd0, 8'd255, 16'd1, 16'd3, 16'd2, 16'd1);
      send_event(KIND_MOVE, POS_FULL);
      send_event(KIND_TICK, POS_FULL);
      repeat (3) send_event(KIND_PULSE, POS_FULL);
      send_event(KIND_TICK, POS_FULL);
      apply_setting(8'd255, 8'd0, 16'd65535, 16'd2, 16'd2, 16'd2);
      send_event(KIND_MOVE, POS_HALF);
      send_event(KIND_TICK, POS_FULL);
      repeat (2) send_event(KIND_PULSE, POS_FULL);
      send_event(KIND_TICK, POS_FULL);
      apply_setting(8'd20, 8'd220, 16'd0, 16'd4, 16'd4, 16'd4);
      send_event(KIND_MOVE, POS_DOWN);
      repeat (12) send_event(KIND_TICK, POS_FULL);
      repeat (4) send_event(KIND_PULSE, POS_FULL);
      send_event(KIND_TICK, POS_FULL);
   endtask

   function automatic logic [REV_W-1:0] pick_revs();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return REV_MAX;
      return REV_W'($urandom_range(1, 40));
   endfunction

   // moves followed by ticks and pulses, with some noise, over several settings
   task automatic test_random_traffic();
      int unsigned phase, goal, len, i, pick;
      logic [DUTY_W-1:0] start_d, full_d;
      logic [RAMP_W-1:0] ramp_ms;
      for (phase = 0; phase < PHASES; phase++) begin
         start_d = DUTY_W'($urandom_range(0, 255));
         full_d  = DUTY_W'($urandom_range(0, 255));
         ramp_ms = ($urandom_range(0, 3) == 0) ? RAMP_W'($urandom_range(1, 65535))
                                               : RAMP_W'($urandom_range(1, 300));
         case (phase)
            0: begin
               start_d = '0;
               full_d  = '1;
               ramp_ms = 16'd1;
            end
            1: begin
               start_d = '1;
               full_d  = '0;
               ramp_ms = '1;
            end
            2: full_d = start_d;
            default: ;
         endcase
         apply_setting(start_d, full_d, ramp_ms, pick_revs(), pick_revs(), pick_revs());
         no_idle = (phase == 3);
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 8) begin
               // well-formed move, run until it stops or the budget runs out
               send_event(KIND_MOVE, POS_W'($urandom_range(0, 2)));
               len = $urandom_range(5, 60);
               for (i = 0; i < len && motor_on; i++) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 55)
                     send_event(KIND_TICK, POS_W'($urandom_range(0, 3)));
                  else if (pick < 97)
                     send_event(KIND_PULSE, POS_W'($urandom_range(0, 3)));
                  else if (pick < 98)
                     send_event(KIND_STOP, POS_W'($urandom_range(0, 3)));
                  else
                     send_event(KIND_MOVE, POS_W'($urandom_range(0, 3)));
               end
            end else begin
               repeat ($urandom_range(1, 8))
                  send_event(KIND_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 3)));
            end
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      reset_motor_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_move_commands();
      test_ramp_corners();
      test_random_traffic();
      settle();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
